// ===== hw/rtl/rkd_pkg.sv =====
// ----------------------------------------------------------------------------
// rkd_pkg
// Shared types, key codes and lookup tables for the remote key RGB dimmer.
// ----------------------------------------------------------------------------
package rkd_pkg;

	// remote key codes
	localparam logic [7:0] BTN_POWER  = 8'd0;
	localparam logic [7:0] BTN_UP     = 8'd1;
	localparam logic [7:0] BTN_DOWN   = 8'd2;
	localparam logic [7:0] BTN_RED    = 8'd3;
	localparam logic [7:0] BTN_GREEN  = 8'd4;
	localparam logic [7:0] BTN_BLUE   = 8'd5;
	localparam logic [7:0] BTN_YELLOW = 8'd6;
	localparam logic [7:0] BTN_DIGIT0 = 8'd7;
	localparam logic [7:0] BTN_DIGIT9 = 8'd16;

	// request kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_KEY  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_IGNORE_GAP       = 2'd0;
	localparam logic [1:0] CFG_FIRST_REPEAT_GAP = 2'd1;
	localparam logic [1:0] CFG_REPEAT_WINDOW    = 2'd2;

	// configuration reset values
	localparam logic [15:0] IGNORE_GAP_RST       = 16'd10;
	localparam logic [15:0] FIRST_REPEAT_GAP_RST = 16'd25;
	localparam logic [15:0] REPEAT_WINDOW_RST    = 16'd50;
	localparam logic [7:0]  LAST_KEY_RST         = 8'd255;

	// channel enable masks, bit0 red, bit1 green, bit2 blue
	localparam logic [2:0] CH_RED   = 3'b001;
	localparam logic [2:0] CH_GREEN = 3'b010;
	localparam logic [2:0] CH_BLUE  = 3'b100;
	localparam logic [2:0] CH_ALL   = 3'b111;

	typedef struct packed {
		logic [15:0] ignore_gap;
		logic [15:0] first_repeat_gap;
		logic [15:0] repeat_window;
	} cfg_t;

	// qualified key handed from the repeat filter to the led control
	typedef struct packed {
		logic       act;
		logic [7:0] code;
	} qual_t;

	typedef struct packed {
		logic [7:0] red_duty;
		logic [7:0] green_duty;
		logic [7:0] blue_duty;
		logic [3:0] level;
		logic       output_on;
	} led_t;

	// brightness index to pwm duty, indexes past the table hold the top value
	function automatic logic [7:0] duty_lut(input logic [3:0] idx);
		logic [7:0] d;
		case (idx)
			4'd0:    d = 8'd0;
			4'd1:    d = 8'd6;
			4'd2:    d = 8'd12;
			4'd3:    d = 8'd18;
			4'd4:    d = 8'd30;
			4'd5:    d = 8'd45;
			4'd6:    d = 8'd60;
			4'd7:    d = 8'd78;
			4'd8:    d = 8'd92;
			4'd9:    d = 8'd109;
			4'd10:   d = 8'd124;
			4'd11:   d = 8'd140;
			default: d = 8'd156;
		endcase
		return d;
	endfunction

	// digit key to brightness index
	function automatic logic [3:0] digit_lut(input logic [3:0] dig);
		logic [3:0] l;
		case (dig)
			4'd0:    l = 4'd0;
			4'd1:    l = 4'd1;
			4'd2:    l = 4'd2;
			4'd3:    l = 4'd4;
			4'd4:    l = 4'd6;
			4'd5:    l = 4'd7;
			4'd6:    l = 4'd8;
			4'd7:    l = 4'd9;
			4'd8:    l = 4'd10;
			default: l = 4'd12;
		endcase
		return l;
	endfunction

endpackage

// ===== hw/rtl/rkd_ifs.sv =====
// ----------------------------------------------------------------------------
// rkd_ifs
// Valid/ready stream interfaces for dimmer events and led results.
// ----------------------------------------------------------------------------
interface rkd_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] key_code;

	modport source (output valid, output op, output key_code, input ready);
	modport sink   (input valid, input op, input key_code, output ready);
endinterface

interface rkd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_duty;
	logic [7:0] green_duty;
	logic [7:0] blue_duty;
	logic [3:0] level;
	logic       output_on;

	modport source (output valid, output red_duty, output green_duty,
		output blue_duty, output level, output output_on, input ready);
	modport sink   (input valid, input red_duty, input green_duty,
		input blue_duty, input level, input output_on, output ready);
endinterface

// ===== hw/rtl/rkd_repeat_qual.sv =====
// ----------------------------------------------------------------------------
// rkd_repeat_qual
// Tick counter and repeat filter for remote key presses.
// ----------------------------------------------------------------------------
module rkd_repeat_qual (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          op,
	input  logic [7:0]    key_code,
	input  rkd_pkg::cfg_t cfg,
	output rkd_pkg::qual_t qual
);
	import rkd_pkg::*;

	logic [15:0] ticks_q;
	logic [7:0]  last_key_q;
	logic [15:0] last_key_time_q;
	logic        repeating_q;

	logic [15:0] gap;
	logic        is_new;
	logic        take;

	// repeat decision
	always_comb begin
		gap    = ticks_q - last_key_time_q;
		is_new = (key_code != last_key_q);
		take   = is_new ||
			(!(gap < cfg.ignore_gap) && (repeating_q || !(gap < cfg.first_repeat_gap)));
		qual.act  = step && (op == OP_KEY) && take;
		qual.code = key_code;
	end

	// tick and repeat state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q         <= '0;
			last_key_q      <= LAST_KEY_RST;
			last_key_time_q <= '0;
			repeating_q     <= 1'b0;
		end else if (step && op == OP_TICK) begin
			ticks_q <= ticks_q + 16'd1;
		end else if (qual.act) begin
			last_key_q      <= key_code;
			last_key_time_q <= ticks_q;
			repeating_q     <= is_new ? 1'b0 : (gap < cfg.repeat_window);
		end
	end

endmodule

// ===== hw/rtl/rkd_led_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkd_led_ctrl
// Power, brightness and channel state driven by qualified keys.
// ----------------------------------------------------------------------------
module rkd_led_ctrl #(
	parameter int LEVELS = 13
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rkd_pkg::qual_t qual,
	output logic           emit,
	output rkd_pkg::led_t  led
);
	import rkd_pkg::*;

	localparam logic [3:0] TOP_LEVEL = 4'(LEVELS - 1);

	logic [3:0] bright_q;
	logic       power_q;
	logic [2:0] chan_q;

	logic [3:0] bright_d;
	logic       power_d;
	logic [2:0] chan_d;
	logic [3:0] digit_off;
	logic [3:0] digit_lv;
	logic [7:0] duty;

	// key action
	always_comb begin
		bright_d  = bright_q;
		power_d   = power_q;
		chan_d    = chan_q;
		emit      = 1'b0;
		digit_off = 4'(qual.code - BTN_DIGIT0);
		digit_lv  = digit_lut(digit_off);
		if (digit_lv > TOP_LEVEL) begin
			digit_lv = TOP_LEVEL;
		end
		if (qual.act) begin
			case (qual.code)
				BTN_POWER: begin
					power_d = !power_q;
					emit    = 1'b1;
				end
				BTN_UP: begin
					if (bright_q < TOP_LEVEL) begin
						bright_d = bright_q + 4'd1;
						emit     = 1'b1;
					end
				end
				BTN_DOWN: begin
					if (bright_q != 4'd0) begin
						bright_d = bright_q - 4'd1;
						emit     = 1'b1;
					end
				end
				BTN_RED: begin
					power_d = 1'b1;
					chan_d  = CH_RED;
					emit    = 1'b1;
				end
				BTN_GREEN: begin
					power_d = 1'b1;
					chan_d  = CH_GREEN;
					emit    = 1'b1;
				end
				BTN_BLUE: begin
					power_d = 1'b1;
					chan_d  = CH_BLUE;
					emit    = 1'b1;
				end
				BTN_YELLOW: begin
					power_d = 1'b1;
					chan_d  = CH_ALL;
					emit    = 1'b1;
				end
				default: begin
					if (qual.code >= BTN_DIGIT0 && qual.code <= BTN_DIGIT9) begin
						bright_d = digit_lv;
						power_d  = 1'b1;
						emit     = 1'b1;
					end
				end
			endcase
		end
	end

	// duty values from the updated state
	always_comb begin
		duty           = duty_lut(bright_d);
		led.red_duty   = (power_d && chan_d[0]) ? duty : 8'd0;
		led.green_duty = (power_d && chan_d[1]) ? duty : 8'd0;
		led.blue_duty  = (power_d && chan_d[2]) ? duty : 8'd0;
		led.level      = bright_d;
		led.output_on  = power_d;
	end

	// led state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= 4'd0;
			power_q  <= 1'b1;
			chan_q   <= CH_ALL;
		end else begin
			bright_q <= bright_d;
			power_q  <= power_d;
			chan_q   <= chan_d;
		end
	end

endmodule

// ===== hw/rtl/remote_key_rgb_dimmer.sv =====
// ----------------------------------------------------------------------------
// remote_key_rgb_dimmer
// RGB led dimmer driven by 10 ms ticks and decoded remote key codes.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      notes
//  item      in   op, key_code                                 tick or key request
//  result    out  red/green/blue_duty, level, output_on        one per led refresh
//  cfg       in   cfg_we, cfg_index, cfg_data                  write only
//
//  one request per cycle while the result is not stalled: an input register
//  feeds a single pass of repeat filter and key logic, whose result lands in
//  the output register.
//  a stalled result holds the output register; the input register keeps
//  taking requests while it is empty, then waits for the result to drain.
//  reset clears all state but the data registers; no clearing pass.
// ----------------------------------------------------------------------------
module remote_key_rgb_dimmer #(
	parameter int LEVELS = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	rkd_item_if.sink    item,
	rkd_result_if.source result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rkd_pkg::*;

	logic       valid_s1;
	logic       op_s1;
	logic [7:0] code_s1;
	logic       advance;

	cfg_t  cfg_q;
	qual_t qual;
	logic  emit;
	led_t  led;

	logic out_valid_q;
	led_t out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ignore_gap       <= IGNORE_GAP_RST;
			cfg_q.first_repeat_gap <= FIRST_REPEAT_GAP_RST;
			cfg_q.repeat_window    <= REPEAT_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IGNORE_GAP:       cfg_q.ignore_gap       <= cfg_data;
				CFG_FIRST_REPEAT_GAP: cfg_q.first_repeat_gap <= cfg_data;
				CFG_REPEAT_WINDOW:    cfg_q.repeat_window    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1   <= item.op;
			code_s1 <= item.key_code;
		end
	end

	rkd_repeat_qual u_qual (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.op       (op_s1),
		.key_code (code_s1),
		.cfg      (cfg_q),
		.qual     (qual)
	);

	rkd_led_ctrl #(
		.LEVELS (LEVELS)
	) u_led (
		.clk    (clk),
		.arst_n (arst_n),
		.qual   (qual),
		.emit   (emit),
		.led    (led)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= led;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.red_duty   = out_q.red_duty;
	assign result.green_duty = out_q.green_duty;
	assign result.blue_duty  = out_q.blue_duty;
	assign result.level      = out_q.level;
	assign result.output_on  = out_q.output_on;

endmodule
